FILE: src/recs_pkg.sv
package recs_pkg;

  localparam int unsigned DefMaxCols = 1024;
  localparam int unsigned DefMaxRows = 1024;

  localparam int unsigned WCSW = 30;
  localparam int unsigned WSW  = 20;
  localparam int unsigned WSQW = 40;
  localparam int unsigned CXW  = 18;
  localparam int unsigned CFW  = 24;
  localparam int unsigned RIW  = 10;

  // register indexes
  localparam logic [1:0] REG_EDGE_MODE = 2'd0;
  localparam logic [1:0] REG_LOW_SUPP  = 2'd1;
  localparam logic [1:0] REG_SLOPE     = 2'd2;
  localparam logic [1:0] REG_GAP_LIM   = 2'd3;

  localparam logic [1:0] MODE_POS = 2'd1;
  localparam logic [1:0] MODE_NEG = 2'd2;

  typedef enum logic [2:0] {
    ST_RUN,
    ST_PREP,
    ST_SQRT,
    ST_DIVX,
    ST_DIVC,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic pix_go;
    logic prep;
    logic sqrt_step;
    logic divx_init;
    logic divx_step;
    logic divc_init;
    logic divc_step;
    logic row_close;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic has_run;
    logic sqrt_done;
    logic div_done;
  } sts_t;

endpackage

FILE: src/row_edge_centroid_scanner_top.sv
// channel | dir | fields (low bit up)
// s_axis  | in  | tdata: grad_x[10:0] grad_y[21:11]; tlast: row_end
// m_axis  | out | tdata: row_index[9:0] center_x_q8[27:10] confidence_q4[51:28]
// cfg     | in  | cfg_index selects register, cfg_data value
// One pixel per cycle inside a row. A row end without a run passes through setup only;
// a row with a run holds the input after its last pixel for one setup,
// 40 root steps, two dividers of one load and 60 steps each, one output load.
// Reset rst is synchronous; config, control and row registers go to defaults.
// Output stalls hold the result; a new result, and the input with it, waits
// until the previous one is taken.
module row_edge_centroid_scanner_top #(
  parameter int unsigned MaxCols = recs_pkg::DefMaxCols,
  parameter int unsigned MaxRows = recs_pkg::DefMaxRows
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // grad_x, grad_y
  input  logic        s_axis_tlast,   // row_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // row_index, center_x_q8, confidence_q4
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data
);
  logic [1:0] edge_mode;
  logic [9:0] low_suppress, slope_ratio_q8, gap_limit;
  recs_pkg::cmd_t cmd;
  recs_pkg::sts_t sts;
  logic [9:0]  row_index;
  logic [17:0] center_x_q8;
  logic [23:0] confidence_q4;

  assign cfg_ready = 1'b1;
  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_mode <= 2'd2;
      low_suppress <= 10'd30;
      slope_ratio_q8 <= 10'd102;
      gap_limit <= 10'd10;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        recs_pkg::REG_EDGE_MODE: edge_mode <= cfg_data[1:0];
        recs_pkg::REG_LOW_SUPP: low_suppress <= cfg_data;
        recs_pkg::REG_SLOPE: slope_ratio_q8 <= cfg_data;
        recs_pkg::REG_GAP_LIM: gap_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  recs_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_last(s_axis_tlast),
    .in_ready(s_axis_tready), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .cmd(cmd), .sts(sts)
  );

  recs_datapath #(.MaxCols(MaxCols), .MaxRows(MaxRows)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .grad_x(s_axis_tdata[10:0]), .grad_y(s_axis_tdata[21:11]),
    .edge_mode(edge_mode), .low_suppress(low_suppress),
    .slope_ratio_q8(slope_ratio_q8), .gap_limit(gap_limit),
    .row_index(row_index), .center_x_q8(center_x_q8), .confidence_q4(confidence_q4)
  );

  assign m_axis_tdata = {4'd0, confidence_q4, center_x_q8, row_index};

`ifndef SYNTH
  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata));
  // padding bits are zero
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tdata[55:52] == 4'd0);
  // configuration is always accepted
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready);
`endif
endmodule

FILE: src/recs_datapath.sv
module recs_datapath #(
  parameter int unsigned MaxCols = recs_pkg::DefMaxCols,
  parameter int unsigned MaxRows = recs_pkg::DefMaxRows
) (
  input  logic                 clk,
  input  logic                 rst,
  input  recs_pkg::cmd_t       cmd,
  output recs_pkg::sts_t       sts,
  input  logic [10:0]          grad_x,
  input  logic [10:0]          grad_y,
  input  logic [1:0]           edge_mode,
  input  logic [9:0]           low_suppress,
  input  logic [9:0]           slope_ratio_q8,
  input  logic [9:0]           gap_limit,
  output logic [9:0]           row_index,
  output logic [17:0]          center_x_q8,
  output logic [23:0]          confidence_q4
);
  localparam int unsigned CW  = $clog2(MaxCols);
  localparam int unsigned RW  = (MaxRows > 1) ? $clog2(MaxRows) : 1;
  localparam logic [CW-1:0] ColMax = CW'(MaxCols - 1);

  logic [CW-1:0]   column_count;
  logic [2*CW-1:0] col_sq;
  logic [RW-1:0]   row_count;
  logic [29:0]   wcs;
  logic [19:0]   ws;
  logic [39:0]   wsq;
  logic [10:0]   run_length;
  logic [10:0]   gap_count;
  logic          row_frozen;

  // polarity filter, slope test and low suppression
  logic signed [10:0] gx, gy;
  logic [10:0] mag, agy;
  logic        keep;
  logic [10:0] s;
  logic [18:0] lhs;
  logic [20:0] rhs;
  always_comb begin
    gx = grad_x;
    gy = grad_y;
    agy = gy[10] ? 11'(-gy) : 11'(gy);
    keep = 1'b1;
    unique case (edge_mode)
      recs_pkg::MODE_POS: begin
        keep = !gx[10];
        mag = gx;
      end
      recs_pkg::MODE_NEG: begin
        keep = (gx <= 0);
        mag = 11'(-gx);
      end
      default: mag = gx[10] ? 11'(-gx) : 11'(gx);
    endcase
    lhs = {agy, 8'd0};
    rhs = 21'(slope_ratio_q8) * 21'(mag);
    if (21'(lhs) > rhs) keep = 1'b0;
    s = (mag > 11'(low_suppress)) ? mag - 11'(low_suppress) : 11'd0;
  end

  // product terms for the sums; the column square is kept as a register
  logic [CW+10:0]   cs;
  logic [2*CW+10:0] ccs;
  logic [30:0] wcs_add;
  logic [20:0] ws_add;
  logic [40:0] wsq_add;
  always_comb begin
    cs = (CW+11)'(column_count) * (CW+11)'(s);
    ccs = (2*CW+11)'(col_sq) * (2*CW+11)'(s);
    wcs_add = 31'(wcs) + 31'(cs);
    ws_add = 21'(ws) + 21'(s);
    wsq_add = 41'(wsq) + 41'(ccs);
  end

  logic [10:0] gap_inc;
  assign gap_inc = (gap_count != 11'h7FF) ? gap_count + 11'd1 : gap_count;

  // finish unit registers
  logic [79:0] rad;
  logic [39:0] root;
  logic [79:0] rem;
  logic [5:0]  step;
  logic [59:0] dvd;
  logic [59:0] quo;
  logic [60:0] drem;
  logic [60:0] dvs;
  logic [6:0]  dstep;
  logic [17:0] cx_hold;

  logic [59:0] prod_ab;
  logic [79:0] qw;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      col_sq <= '0;
      row_count <= '0;
      wcs <= '0;
      ws <= '0;
      wsq <= '0;
      run_length <= '0;
      gap_count <= '0;
      row_frozen <= 1'b0;
    end else begin
      if (cmd.pix_go) begin
        if (!row_frozen && keep) begin
          if (s != 0) begin
            wcs <= wcs_add[30] ? '1 : wcs_add[29:0];
            ws <= ws_add[20] ? '1 : ws_add[19:0];
            wsq <= wsq_add[40] ? '1 : wsq_add[39:0];
            if (run_length != 11'h7FF) run_length <= run_length + 11'd1;
          end else if (run_length != 0) begin
            gap_count <= gap_inc;
            if (gap_inc > 11'(gap_limit)) begin
              if (run_length > 11'd1) begin
                row_frozen <= 1'b1;
              end else begin
                wcs <= '0;
                ws <= '0;
                wsq <= '0;
                run_length <= '0;
              end
            end
          end
        end
        if (column_count != ColMax) begin
          column_count <= column_count + 1'b1;
          // (c+1)^2 = c^2 + 2c + 1
          col_sq <= col_sq + (2*CW)'({column_count, 1'b1});
        end
      end
      if (cmd.row_close) begin
        wcs <= '0;
        ws <= '0;
        wsq <= '0;
        run_length <= '0;
        gap_count <= '0;
        row_frozen <= 1'b0;
        column_count <= '0;
        col_sq <= '0;
        row_count <= (row_count == RW'(MaxRows - 1)) ? '0 : row_count + 1'b1;
      end
    end
  end

  // square root and divisions run step by step once per row
  logic [81:0] trial;
  logic [79:0] rem_sh;
  always_comb begin
    rem_sh = {rem[77:0], rad[79:78]};
    trial = {2'b0, rem_sh} - {root, 2'b01};
  end

  logic [61:0] dtry;
  assign dtry = {drem[59:0], dvd[59]} - {1'b0, dvs};

  // radicand terms Q*W and S*S
  always_comb begin
    qw = 80'(wsq) * 80'(ws);
    prod_ab = 60'(wcs) * 60'(wcs);
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      rad <= (qw > 80'(prod_ab)) ? qw - 80'(prod_ab) : '0;
      root <= '0;
      rem <= '0;
      step <= '0;
    end
    if (cmd.sqrt_step) begin
      if (!trial[81]) begin
        rem <= trial[79:0];
        root <= {root[38:0], 1'b1};
      end else begin
        rem <= rem_sh;
        root <= {root[38:0], 1'b0};
      end
      rad <= {rad[77:0], 2'b00};
      step <= step + 6'd1;
    end
    if (cmd.divx_init) begin
      dvd <= 60'({wcs, 8'd0}) + 60'(ws >> 1);
      dvs <= 61'(ws);
      drem <= '0;
      quo <= '0;
      dstep <= '0;
    end
    if (cmd.divc_init) begin
      dvd <= 60'({ws, 4'd0}) * 60'(ws);
      dvs <= 61'(ws) + 61'(root);
      drem <= '0;
      quo <= '0;
      dstep <= '0;
    end
    if (cmd.divx_step || cmd.divc_step) begin
      if (!dtry[61]) begin
        drem <= dtry[60:0];
        quo <= {quo[58:0], 1'b1};
      end else begin
        drem <= {drem[59:0], dvd[59]};
        quo <= {quo[58:0], 1'b0};
      end
      dvd <= {dvd[58:0], 1'b0};
      dstep <= dstep + 7'd1;
    end
    // centroid is parked until the whole result is loaded
    if (cmd.divc_init) begin
      cx_hold <= (ws == 0) ? '0 : ((quo[59:18] != 0) ? '1 : quo[17:0]);
    end
    if (cmd.out_load) begin
      center_x_q8 <= cx_hold;
      confidence_q4 <= (ws == 0) ? '0 : ((quo[59:24] != 0) ? '1 : quo[23:0]);
      row_index <= 10'(row_count);
    end
  end

  assign sts.has_run = (run_length != 0);
  assign sts.sqrt_done = (step == 6'd39) && cmd.sqrt_step;
  assign sts.div_done = (dstep == 7'd59) && (cmd.divx_step || cmd.divc_step);
endmodule

FILE: src/recs_ctrl.sv
module recs_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output recs_pkg::cmd_t  cmd,
  input  recs_pkg::sts_t  sts
);
  recs_pkg::state_t state, state_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      recs_pkg::ST_RUN:
        if (in_valid && in_ready && in_last) state_next = recs_pkg::ST_PREP;
      recs_pkg::ST_PREP:
        state_next = sts.has_run ? recs_pkg::ST_SQRT : recs_pkg::ST_RUN;
      recs_pkg::ST_SQRT: if (sts.sqrt_done) state_next = recs_pkg::ST_DIVX;
      recs_pkg::ST_DIVX: if (sts.div_done) state_next = recs_pkg::ST_DIVC;
      recs_pkg::ST_DIVC: if (sts.div_done) state_next = recs_pkg::ST_OUT;
      recs_pkg::ST_OUT: if (!out_valid || out_ready) state_next = recs_pkg::ST_RUN;
      default: state_next = recs_pkg::ST_RUN;
    endcase
  end

  logic first;
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= recs_pkg::ST_RUN;
      out_valid <= 1'b0;
      first <= 1'b0;
    end else begin
      state <= state_next;
      first <= (state != state_next);
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // commands
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      recs_pkg::ST_RUN: begin
        in_ready = 1'b1;
        cmd.pix_go = in_valid;
      end
      // row end: run state now includes the last pixel
      recs_pkg::ST_PREP: begin
        cmd.prep = sts.has_run;
        cmd.row_close = !sts.has_run;
      end
      recs_pkg::ST_SQRT: cmd.sqrt_step = 1'b1;
      recs_pkg::ST_DIVX: begin
        cmd.divx_init = first;
        cmd.divx_step = !first;
      end
      recs_pkg::ST_DIVC: begin
        cmd.divc_init = first;
        cmd.divc_step = !first;
      end
      recs_pkg::ST_OUT: begin
        cmd.out_load = !out_valid || out_ready;
        cmd.row_close = cmd.out_load;
      end
      default: ;
    endcase
  end
endmodule

FILE: tb/row_edge_centroid_scanner_top_test.sv
`timescale 1ns / 100ps

module row_edge_centroid_scanner_top_test;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned SettleCycles = 250;
  localparam int unsigned PtW = recs_pkg::RIW + recs_pkg::CXW + recs_pkg::CFW;

  // packed from the top bit down, so row_index lands in the low bits
  typedef struct packed {
    logic [recs_pkg::CFW-1:0] confidence_q4;
    logic [recs_pkg::CXW-1:0] center_x_q8;
    logic [recs_pkg::RIW-1:0] row_index;
  } edge_point_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = recs_pkg::REG_EDGE_MODE;
  logic [9:0]  cfg_data = '0;

  row_edge_centroid_scanner_top u_dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #4 clk = ~clk;

  // shadow of the configuration registers
  logic [1:0] mode_q = recs_pkg::MODE_NEG;
  logic [9:0] suppress_q = 10'd30;
  logic [9:0] slope_q = 10'd102;
  logic [9:0] gap_lim_q = 10'd10;

  // shadow of the row accumulators
  int unsigned                 col_q;
  logic [recs_pkg::RIW-1:0]    row_q;
  longint unsigned             wcol_q, wsum_q, wsq_q;
  int unsigned                 run_q, gaps_q;
  bit                          frozen_q;

  edge_point_t pending_points[$];
  int unsigned errors, n_pixels, n_points, n_rows, cycles;
  bit tx_steady, rx_steady;

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic longint unsigned sat_sum(longint unsigned a, longint unsigned b,
                                              longint unsigned top);
    return (a + b > top) ? top : a + b;
  endfunction

  // integer square root, one result bit at a time
  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned r, t;
    r = 0;
    for (int k = 30; k >= 0; k--) begin
      t = r | (64'd1 << k);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // one pixel into the accumulators
  function automatic void accumulate(int gx, int gy);
    int mag, agy, s;
    agy = gy < 0 ? -gy : gy;
    if (mode_q == recs_pkg::MODE_POS) begin
      if (gx < 0) return;
      mag = gx;
    end else if (mode_q == recs_pkg::MODE_NEG) begin
      if (gx > 0) return;
      mag = -gx;
    end else begin
      mag = gx < 0 ? -gx : gx;
    end
    if (longint'(agy) * 256 > longint'(slope_q) * mag) return;
    s = mag > int'(suppress_q) ? mag - int'(suppress_q) : 0;
    if (s > 0) begin
      wcol_q = sat_sum(wcol_q, longint'(col_q) * s, (64'd1 << recs_pkg::WCSW) - 1);
      wsum_q = sat_sum(wsum_q, s, (64'd1 << recs_pkg::WSW) - 1);
      wsq_q = sat_sum(wsq_q, longint'(col_q) * col_q * s, (64'd1 << recs_pkg::WSQW) - 1);
      if (run_q < 2047) run_q++;
    end else if (run_q > 0) begin
      if (gaps_q < 2047) gaps_q++;
      if (gaps_q > gap_lim_q) begin
        if (run_q > 1) frozen_q = 1'b1;
        else begin
          wcol_q = 0; wsum_q = 0; wsq_q = 0; run_q = 0;
        end
      end
    end
  endfunction

  // predict the edge point a pixel causes, if any
  function automatic void predict_pixel(int gx, int gy, bit last);
    edge_point_t p;
    longint unsigned a, b, rt, cx, cf;
    if (!frozen_q) accumulate(gx, gy);
    if (col_q < recs_pkg::DefMaxCols - 1) col_q++;
    if (!last) return;
    if (run_q > 0) begin
      cx = 0; cf = 0;
      if (wsum_q > 0) begin
        a = wsq_q * wsum_q;
        b = wcol_q * wcol_q;
        rt = int_root(a > b ? a - b : 0);
        cx = (wcol_q * 256 + wsum_q / 2) / wsum_q;
        if (cx > (64'd1 << recs_pkg::CXW) - 1) cx = (64'd1 << recs_pkg::CXW) - 1;
        cf = (16 * wsum_q * wsum_q) / (wsum_q + rt);
        if (cf > (64'd1 << recs_pkg::CFW) - 1) cf = (64'd1 << recs_pkg::CFW) - 1;
      end
      p.row_index = row_q;
      p.center_x_q8 = cx[recs_pkg::CXW-1:0];
      p.confidence_q4 = cf[recs_pkg::CFW-1:0];
      pending_points = {pending_points, p};
    end
    wcol_q = 0; wsum_q = 0; wsq_q = 0; run_q = 0;
    gaps_q = 0; frozen_q = 1'b0; col_q = 0;
    row_q++;
    n_rows++;
  endfunction

  // send one pixel request
  task automatic push_pixel(input int gx, input int gy, input bit last);
    logic [10:0] x, y;
    x = gx[10:0];
    y = gy[10:0];
    if (!tx_steady && $urandom_range(99) < 16) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, y, x};
    s_axis_tlast <= last;
    do @(posedge clk); while (!s_axis_tready);
    predict_pixel(gx, gy, last);
    n_pixels++;
  endtask

  // stop sending, wait for all points and let the block settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // registers change only while the block is idle
  task automatic write_reg(input logic [1:0] idx, input logic [9:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      recs_pkg::REG_EDGE_MODE: mode_q = val[1:0];
      recs_pkg::REG_LOW_SUPP:  suppress_q = val;
      recs_pkg::REG_SLOPE:     slope_q = val;
      recs_pkg::REG_GAP_LIM:   gap_lim_q = val;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [9:0] m, input logic [9:0] lo,
                            input logic [9:0] sl, input logic [9:0] gl);
    drain();
    write_reg(recs_pkg::REG_EDGE_MODE, m);
    write_reg(recs_pkg::REG_LOW_SUPP, lo);
    write_reg(recs_pkg::REG_SLOPE, sl);
    write_reg(recs_pkg::REG_GAP_LIM, gl);
  endtask

  // mostly edge-like pixels for the current mode, some gaps and some noise
  task automatic random_pixel(input bit last);
    int r, mag, gx, gy, gmax;
    r = $urandom_range(99);
    if (r < 20) begin
      gx = int'($urandom_range(2040)) - 1020;
      gy = int'($urandom_range(2040)) - 1020;
    end else begin
      if (r < 40) mag = $urandom_range(suppress_q > 1020 ? 1020 : suppress_q);
      else mag = $urandom_range(suppress_q >= 1020 ? 1020 : suppress_q + 1, 1020);
      if (mode_q == recs_pkg::MODE_POS) gx = mag;
      else if (mode_q == recs_pkg::MODE_NEG) gx = -mag;
      else gx = $urandom_range(1) ? mag : -mag;
      gmax = (slope_q * mag) / 256;
      if (gmax > 1020) gmax = 1020;
      gy = $urandom_range(gmax);
      if ($urandom_range(1)) gy = -gy;
    end
    push_pixel(gx, gy, last);
  endtask

  task automatic random_rows(input int rows);
    int len;
    for (int i = 0; i < rows; i++) begin
      len = ($urandom_range(99) < 88) ? 1 : $urandom_range(3, 24);
      for (int j = 0; j < len; j++) random_pixel(j == len - 1);
    end
  endtask

  // default registers: negative edges, gaps, rejected slopes, empty rows
  task automatic test_defaults();
    push_pixel(-200, 0, 0);
    push_pixel(-1020, -20, 0);
    push_pixel(-500, 40, 0);
    push_pixel(0, 0, 0);
    push_pixel(0, 5, 0);
    push_pixel(-1020, 1020, 0);
    push_pixel(-300, 0, 1);
    push_pixel(100, 0, 0);
    push_pixel(0, 0, 1);
    push_pixel(-60, 0, 1);
  endtask

  // each edge mode, including the unused code, and suppression/slope extremes
  task automatic test_modes();
    set_config(10'd0, 10'd0, 10'd1023, 10'd10);
    push_pixel(1020, -1020, 0);
    push_pixel(-1, 0, 0);
    push_pixel(700, 100, 1);
    write_reg(recs_pkg::REG_EDGE_MODE, 10'd1);
    push_pixel(-400, 0, 0);
    push_pixel(400, -3, 1);
    write_reg(recs_pkg::REG_EDGE_MODE, 10'h3FF);
    write_reg(recs_pkg::REG_SLOPE, 10'd0);
    push_pixel(-900, 1, 0);
    push_pixel(-900, 0, 0);
    push_pixel(800, 0, 1);
    set_config(10'd2, 10'd1020, 10'd1023, 10'd10);
    push_pixel(-1020, 0, 0);
    push_pixel(-1020, 512, 1);
  endtask

  // gap limits: lone pixel discarded, longer run frozen
  task automatic test_gaps();
    set_config(10'd0, 10'd30, 10'd1023, 10'd0);
    push_pixel(300, 0, 0);
    push_pixel(10, 0, 0);
    push_pixel(250, 0, 0);
    push_pixel(-260, 0, 0);
    push_pixel(5, 0, 0);
    push_pixel(900, 0, 0);
    push_pixel(0, 0, 1);
    write_reg(recs_pkg::REG_GAP_LIM, 10'd1023);
    push_pixel(400, 0, 0);
    push_pixel(0, 0, 0);
    push_pixel(400, 0, 1);
  endtask

  // one very long row: column count and weight sum saturate
  task automatic test_saturation();
    set_config(10'd0, 10'd0, 10'd1023, 10'd1023);
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    for (int i = 0; i < 1030; i++) push_pixel(($urandom_range(1) ? 1020 : -1020),
                                              int'($urandom_range(40)) - 20, i == 1029);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // random rows under several register settings
  task automatic test_random();
    set_config(10'd0, 10'd30, 10'd1023, 10'd3);
    random_rows(60);
    set_config(10'd1, 10'd0, 10'd256, 10'd0);
    random_rows(30);
    drain();
    random_rows(30);
    set_config(10'd2, 10'd500, 10'd50, 10'd1023);
    random_rows(40);
    set_config(10'd3, 10'd5, 10'd0, 10'd10);
    random_rows(40);
  endtask

  // output side: random back-pressure
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= rx_steady || ($urandom_range(99) >= 16);
  end

  // compare each accepted edge point against the oldest prediction
  always @(posedge clk) begin
    edge_point_t got, want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[PtW-1:0];
      if (pending_points.size() == 0) begin
        report($sformatf("unexpected edge point %h", m_axis_tdata));
      end else begin
        want = pending_points.pop_front();
        n_points++;
        if (got.row_index != want.row_index)
          report($sformatf("row_index %0d, want %0d", got.row_index, want.row_index));
        if (got.center_x_q8 != want.center_x_q8)
          report($sformatf("row %0d center_x_q8 %0d, want %0d", want.row_index,
                           got.center_x_q8, want.center_x_q8));
        if (got.confidence_q4 != want.confidence_q4)
          report($sformatf("row %0d confidence_q4 %0d, want %0d", want.row_index,
                           got.confidence_q4, want.confidence_q4));
      end
      if (m_axis_tdata[55:PtW] != '0) report("nonzero tdata padding");
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    col_q = 0; row_q = '0; wcol_q = 0; wsum_q = 0; wsq_q = 0;
    run_q = 0; gaps_q = 0; frozen_q = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_modes();
    test_gaps();
    test_saturation();
    test_random();
    drain();
    $display("Covered %0d pixels in %0d rows, %0d edge points checked,", n_pixels,
             n_rows, n_points);
    $display("all edge modes, gap/freeze handling, column and sum saturation.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/recs_pkg.sv
src/recs_datapath.sv
src/recs_ctrl.sv
src/row_edge_centroid_scanner_top.sv
tb/row_edge_centroid_scanner_top_test.sv
